/* design/srpt_pkg.sv */
package srpt_pkg;

  localparam int unsigned NUM_STATES_DEF  = 16;
  localparam int unsigned NUM_PERIODS_DEF = 8;

  localparam logic [10:0] FULL_SHARE = 11'd1024;
  localparam logic [32:0] SUM_MAX    = {33{1'b1}};
  localparam logic [31:0] PLEN_RST   = 32'd4000000;

  localparam logic       CMD_UPDATE = 1'b0;
  localparam logic       CMD_READ   = 1'b1;
  localparam logic [1:0] ACT_KEEP   = 2'd0;
  localparam logic [1:0] ACT_ENTER  = 2'd1;
  localparam logic [1:0] ACT_IDLE   = 2'd2;

  localparam logic [6:0] SHARE_STEPS = 7'd10;
  localparam logic [6:0] COUNT_STEPS = 7'd64;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] rem_init;
    logic [6:0]  steps;
  } div_ctl_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] rem;
    logic [9:0]  qlow;
    logic [6:0]  qsat;
    logic [6:0]  qmod;
  } div_stat_t;

  typedef struct packed {
    logic        we;
    logic [5:0]  slot;
    logic [4:0]  idx;
    logic [10:0] data;
  } hist_wr_t;

endpackage

/* design/srpt_if.sv */
interface srpt_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] now;
  logic [1:0]  state_action;
  logic [3:0]  new_state;
  logic [3:0]  read_state;
  logic [2:0]  read_age;

  modport source (output valid, cmd, now, state_action, new_state, read_state, read_age,
                  input ready);
  modport sink (input valid, cmd, now, state_action, new_state, read_state, read_age,
                output ready);
endinterface

interface srpt_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] cell_value;
  logic [10:0] period_total;
  logic [2:0]  current_slot;
  logic        is_active;

  modport source (output valid, cell_value, period_total, current_slot, is_active,
                  input ready);
  modport sink (input valid, cell_value, period_total, current_slot, is_active,
                output ready);
endinterface

/* design/state_residency_period_tracker.sv */
// channel  direction  transaction
// in_i     sink       cmd, now, state_action, new_state, read_state, read_age
// out_o    source     cell_value, period_total, current_slot, is_active
// cfg      write      cfg_we_i / cfg_wdata_i, period_length
//
// A read result sums one history read per state; it then passes S_RDW and S_DONE.
// An update result takes up to two share divisions and a period count, then writes the
// current history slot and min(periods ended - 1, NUM_PERIODS) further slots, one state per cycle.
// in_i is ready only when idle; a finished result waits in the output register.
// Reset clears the tracker registers and history valid bits at once; no clearing pass is needed.
module state_residency_period_tracker #(
  parameter int unsigned NUM_STATES  = srpt_pkg::NUM_STATES_DEF,
  parameter int unsigned NUM_PERIODS = srpt_pkg::NUM_PERIODS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  srpt_in_if.sink     in_i,
  srpt_out_if.source  out_o
);
  import srpt_pkg::*;

  localparam int unsigned SW = $clog2(NUM_PERIODS);
  localparam int unsigned IW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam logic [IW-1:0] IDX_LAST  = IW'(NUM_STATES - 1);
  localparam logic [SW-1:0] SLOT_LAST = SW'(NUM_PERIODS - 1);
  localparam logic [7:0]    NP8       = 8'(NUM_PERIODS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_RDW  = 4'd2;
  localparam logic [3:0] S_U0   = 4'd3;
  localparam logic [3:0] S_U1   = 4'd4;
  localparam logic [3:0] S_U2   = 4'd5;
  localparam logic [3:0] S_CR   = 4'd6;
  localparam logic [3:0] S_CRB  = 4'd7;
  localparam logic [3:0] S_SDIV = 4'd8;
  localparam logic [3:0] S_U3   = 4'd9;
  localparam logic [3:0] S_CDIV = 4'd10;
  localparam logic [3:0] S_COPY = 4'd11;
  localparam logic [3:0] S_FILL = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;
  localparam logic [3:0] S_SUM  = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  logic [3:0]  st_q;
  logic [31:0] plen_q;

  logic        cmd_q;
  logic [63:0] now_q;
  logic [1:0]  act_q;
  logic [3:0]  ns_q;
  logic [3:0]  rs_q;

  logic [63:0] pb_q;
  logic [63:0] last_q;
  logic [SW-1:0] slot_q;
  logic [3:0]  act_st_q;
  logic        av_q;
  logic [32:0] ts_q [NUM_STATES];
  logic [10:0] sh_q [NUM_STATES];

  logic [63:0] work_q;
  logic        gtl_q;
  logic [32:0] sval_q;
  logic        second_q;
  logic        cnt_nz_q;
  logic [31:0] rem_q;
  logic [6:0]  qsat_q;
  logic [6:0]  qmod_q;
  logic [6:0]  fill_q;
  logic [IW-1:0] idx_q;
  logic [IW-1:0] ridx_q;
  logic        rv_q;
  logic [SW-1:0] wslot_q;
  logic [SW-1:0] rslot_q;
  logic [15:0] sum_q;
  logic [10:0] cell_q;

  logic        out_valid_q;
  logic [10:0] out_cell_q;
  logic [10:0] out_total_q;
  logic [2:0]  out_slot_q;
  logic        out_act_q;

  div_ctl_t    div_ctl;
  div_stat_t   div_stat;
  hist_wr_t    hist_wr;
  logic [10:0] hist_rd;

  logic [IW-1:0] act_ix;
  logic [64:0]   end_sum;
  logic [64:0]   credit_sum;
  logic [32:0]   credit_sat;
  logic          sh_sat;
  logic [63:0]   diff;
  logic          gtpb;
  logic [7:0]    age_mod;
  logic [7:0]    rslot_w;
  logic [7:0]    slot_add;
  logic [6:0]    fill_w;
  logic [7:0]    slot_ext;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + SW'(1);
  endfunction

  assign act_ix     = IW'(act_st_q);
  assign end_sum    = {1'b0, pb_q} + 65'(plen_q);
  assign credit_sum = 65'(ts_q[act_ix]) + 65'(work_q);
  assign credit_sat = (credit_sum[64:33] != '0) ? SUM_MAX : credit_sum[32:0];
  assign sh_sat     = sval_q >= {1'b0, plen_q};
  assign diff       = now_q - pb_q;
  assign gtpb       = now_q > pb_q;
  assign fill_w     = qsat_q - 7'd1;
  assign slot_add   = 8'(slot_q) + {1'b0, qmod_q};
  assign slot_ext   = 8'(slot_q);

  always_comb begin
    age_mod = 8'(in_i.read_age);
    for (int k = 0; k < 4; k++) begin
      if (age_mod >= NP8) begin
        age_mod = age_mod - NP8;
      end
    end
    rslot_w = 8'(slot_q) + NP8 - age_mod;
    if (rslot_w >= NP8) begin
      rslot_w = rslot_w - NP8;
    end
  end

  always_comb begin
    div_ctl = '0;
    if (st_q == S_CRB && !sh_sat) begin
      div_ctl.start    = 1'b1;
      div_ctl.rem_init = sval_q[31:0];
      div_ctl.steps    = SHARE_STEPS;
    end else if (st_q == S_U3 && gtpb) begin
      div_ctl.start = 1'b1;
      div_ctl.num   = diff;
      div_ctl.steps = COUNT_STEPS;
    end
  end

  always_comb begin
    hist_wr      = '0;
    hist_wr.slot = 6'(wslot_q);
    hist_wr.idx  = 5'(idx_q);
    if (st_q == S_COPY) begin
      hist_wr.we   = 1'b1;
      hist_wr.data = sh_q[idx_q];
    end else if (st_q == S_FILL) begin
      hist_wr.we   = 1'b1;
      hist_wr.data = (av_q && idx_q == act_ix) ? FULL_SHARE : '0;
    end
  end

  srpt_divider #(
    .NUM_PERIODS (NUM_PERIODS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (div_ctl),
    .divisor_i (plen_q),
    .stat_o    (div_stat)
  );

  srpt_history #(
    .NUM_STATES  (NUM_STATES),
    .NUM_PERIODS (NUM_PERIODS)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (hist_wr),
    .rd_slot_i (6'(rslot_q)),
    .rd_idx_i  (5'(idx_q)),
    .rd_data_o (hist_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= PLEN_RST;
    end else if (cfg_we_i) begin
      plen_q <= (cfg_wdata_i == '0) ? 32'd1 : cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      pb_q        <= '0;
      last_q      <= '0;
      slot_q      <= '0;
      act_st_q    <= '0;
      av_q        <= 1'b0;
      for (int k = 0; k < NUM_STATES; k++) begin
        ts_q[k] <= '0;
        sh_q[k] <= '0;
      end
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rv_q <= (st_q == S_RD);
      if (rv_q) begin
        sum_q <= sum_q + 16'(hist_rd);
        if (5'(ridx_q) == {1'b0, rs_q}) begin
          cell_q <= hist_rd;
        end
      end
      if (out_o.ready && st_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (in_i.valid) begin
            cmd_q    <= in_i.cmd;
            now_q    <= in_i.now;
            act_q    <= in_i.state_action;
            ns_q     <= in_i.new_state;
            rs_q     <= in_i.read_state;
            rslot_q  <= SW'(rslot_w);
            idx_q    <= '0;
            sum_q    <= '0;
            cell_q   <= '0;
            second_q <= 1'b0;
            st_q     <= (in_i.cmd == CMD_READ) ? S_RD : S_U0;
          end
        end
        S_RD: begin
          ridx_q <= idx_q;
          idx_q  <= idx_q + IW'(1);
          if (idx_q == IDX_LAST) begin
            st_q <= S_RDW;
          end
        end
        S_RDW: begin
          st_q <= S_DONE;
        end
        S_U0: begin
          work_q <= end_sum[64] ? {64{1'b1}} : end_sum[63:0];
          st_q   <= S_U1;
        end
        S_U1: begin
          work_q <= (now_q < work_q) ? now_q : work_q;
          gtl_q  <= now_q > last_q;
          st_q   <= S_U2;
        end
        S_U2: begin
          work_q <= (gtl_q && work_q > last_q) ? work_q - last_q : '0;
          st_q   <= S_CR;
        end
        S_CR: begin
          if (av_q) begin
            ts_q[act_ix] <= credit_sat;
            sval_q       <= credit_sat;
            st_q         <= S_CRB;
          end else begin
            st_q <= second_q ? S_FIN : S_U3;
          end
        end
        S_CRB: begin
          if (sh_sat) begin
            sh_q[act_ix] <= FULL_SHARE;
            st_q         <= second_q ? S_FIN : S_U3;
          end else begin
            st_q <= S_SDIV;
          end
        end
        S_SDIV: begin
          if (!div_stat.busy) begin
            sh_q[act_ix] <= {1'b0, div_stat.qlow};
            st_q         <= second_q ? S_FIN : S_U3;
          end
        end
        S_U3: begin
          if (gtpb) begin
            st_q <= S_CDIV;
          end else begin
            cnt_nz_q <= 1'b0;
            st_q     <= S_FIN;
          end
        end
        S_CDIV: begin
          if (!div_stat.busy) begin
            rem_q  <= div_stat.rem;
            qsat_q <= div_stat.qsat;
            qmod_q <= div_stat.qmod;
            idx_q  <= '0;
            wslot_q <= next_slot(slot_q);
            if (div_stat.qsat == '0) begin
              cnt_nz_q <= 1'b0;
              st_q     <= S_FIN;
            end else begin
              cnt_nz_q <= 1'b1;
              st_q     <= S_COPY;
            end
          end
        end
        S_COPY: begin
          sh_q[idx_q] <= '0;
          ts_q[idx_q] <= '0;
          if (idx_q == IDX_LAST) begin
            idx_q   <= '0;
            fill_q  <= fill_w;
            wslot_q <= next_slot(wslot_q);
            if (fill_w == '0) begin
              second_q <= 1'b1;
              work_q   <= 64'(rem_q);
              st_q     <= S_CR;
            end else begin
              st_q <= S_FILL;
            end
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        S_FILL: begin
          if (idx_q == IDX_LAST) begin
            idx_q   <= '0;
            fill_q  <= fill_q - 7'd1;
            wslot_q <= next_slot(wslot_q);
            if (fill_q == 7'd1) begin
              second_q <= 1'b1;
              work_q   <= 64'(rem_q);
              st_q     <= S_CR;
            end
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        S_FIN: begin
          if (cnt_nz_q) begin
            slot_q <= SW'((slot_add >= NP8) ? slot_add - NP8 : slot_add);
            pb_q   <= now_q - 64'(rem_q);
          end
          last_q <= now_q;
          if (act_q == ACT_ENTER && 32'(ns_q) < NUM_STATES) begin
            act_st_q <= ns_q;
            av_q     <= 1'b1;
          end else if (act_q == ACT_IDLE) begin
            av_q <= 1'b0;
          end
          idx_q  <= '0;
          sum_q  <= '0;
          cell_q <= '0;
          st_q   <= S_SUM;
        end
        S_SUM: begin
          sum_q <= sum_q + 16'(sh_q[idx_q]);
          if (av_q && 5'(idx_q) == {1'b0, act_st_q}) begin
            cell_q <= sh_q[idx_q];
          end
          idx_q <= idx_q + IW'(1);
          if (idx_q == IDX_LAST) begin
            st_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_cell_q  <= cell_q;
            out_total_q <= (sum_q > 16'(FULL_SHARE)) ? FULL_SHARE : sum_q[10:0];
            out_slot_q  <= slot_ext[2:0];
            out_act_q   <= av_q;
            st_q        <= S_IDLE;
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready         = st_q == S_IDLE;
  assign out_o.valid        = out_valid_q;
  assign out_o.cell_value   = out_cell_q;
  assign out_o.period_total = out_total_q;
  assign out_o.current_slot = out_slot_q;
  assign out_o.is_active    = out_act_q;

  a_fill_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_FILL |-> fill_q != '0)
    else $error("fill pass with no slots left");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q) == S_DONE)
    else $error("result raised outside done state");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slot_q) < NUM_PERIODS)
    else $error("slot index out of range");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_CRB && !sh_sat) |=> div_stat.busy)
    else $error("share division did not start");

endmodule

/* design/srpt_divider.sv */
module srpt_divider #(
  parameter int unsigned NUM_PERIODS = srpt_pkg::NUM_PERIODS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srpt_pkg::div_ctl_t  ctl_i,
  input  logic [31:0]         divisor_i,
  output srpt_pkg::div_stat_t stat_o
);
  import srpt_pkg::*;

  localparam logic [7:0] NP8  = 8'(NUM_PERIODS);
  localparam logic [7:0] SAT8 = 8'(NUM_PERIODS + 1);

  logic [31:0] rem_q;
  logic [63:0] num_q;
  logic [9:0]  qlow_q;
  logic [6:0]  qsat_q;
  logic [6:0]  qmod_q;
  logic [6:0]  cnt_q;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;
  logic [7:0]  qsat_w;
  logic [7:0]  qmod_w;

  assign trial  = {rem_q, num_q[63]};
  assign fits   = trial >= {1'b0, divisor_i};
  assign diff   = trial - {1'b0, divisor_i};
  assign qsat_w = {qsat_q, fits};
  assign qmod_w = {qmod_q, fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl_i.start) begin
      cnt_q <= ctl_i.steps;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q  <= ctl_i.rem_init;
      num_q  <= ctl_i.num;
      qlow_q <= '0;
      qsat_q <= '0;
      qmod_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q  <= fits ? diff[31:0] : trial[31:0];
      num_q  <= {num_q[62:0], 1'b0};
      qlow_q <= {qlow_q[8:0], fits};
      qsat_q <= (qsat_w > SAT8) ? SAT8[6:0] : qsat_w[6:0];
      qmod_q <= (qmod_w >= NP8) ? 7'(qmod_w - NP8) : qmod_w[6:0];
    end
  end

  assign stat_o.busy = cnt_q != '0;
  assign stat_o.rem  = rem_q;
  assign stat_o.qlow = qlow_q;
  assign stat_o.qsat = qsat_q;
  assign stat_o.qmod = qmod_q;

endmodule

/* design/srpt_history.sv */
module srpt_history #(
  parameter int unsigned NUM_STATES  = srpt_pkg::NUM_STATES_DEF,
  parameter int unsigned NUM_PERIODS = srpt_pkg::NUM_PERIODS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srpt_pkg::hist_wr_t wr_i,
  input  logic [5:0]         rd_slot_i,
  input  logic [4:0]         rd_idx_i,
  output logic [10:0]        rd_data_o
);
  import srpt_pkg::*;

  localparam int unsigned SW    = $clog2(NUM_PERIODS);
  localparam int unsigned IW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int unsigned DEPTH = 2 ** (SW + IW);

  logic [10:0]         mem [DEPTH];
  logic [2**SW-1:0]    valid_q;
  logic [10:0]         rdata_q;
  logic                rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[{wr_i.slot[SW-1:0], wr_i.idx[IW-1:0]}] <= wr_i.data;
    end
    rdata_q <= mem[{rd_slot_i[SW-1:0], rd_idx_i[IW-1:0]}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        valid_q[wr_i.slot[SW-1:0]] <= 1'b1;
      end
      rvalid_q <= valid_q[rd_slot_i[SW-1:0]];
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule
